>>> hdl/mesb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesb_pkg
// Shared types, codes and helpers for the minimum energy seam backtrack block.
// ----------------------------------------------------------------------------
package mesb_pkg;

   localparam int MAX_DIM_DEFAULT = 64;
   localparam int DIM_LIMIT       = 64;

   localparam int COST_W  = 32;
   localparam int IDX_W   = 6;
   localparam int DIM_W   = 7;
   localparam int POS_W   = 12;
   localparam int CSR_I_W = 2;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   localparam logic [CSR_I_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_I_W-1:0] CSR_COLS = 2'd1;
   localparam logic [CSR_I_W-1:0] CSR_DIR  = 2'd2;

   // run setup handed from the register block to the sequencer
   typedef struct packed {
      logic             horiz;
      logic [DIM_W-1:0] len;
      logic [DIM_W-1:0] span;
      logic [DIM_W-1:0] cols;
   } run_cfg_type;

   function automatic logic [DIM_W-1:0] clamp_dim(
      input logic [DIM_W-1:0] v,
      input logic [DIM_W-1:0] cap
   );
      logic [DIM_W-1:0] res;
      res = v;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (v > cap) begin
         res = cap;
      end
      return res;
   endfunction

   function automatic logic [31:0] cell_addr(
      input logic [IDX_W-1:0] r,
      input logic [IDX_W-1:0] c,
      input logic [31:0]      dim
   );
      return 32'(r) * dim + 32'(c);
   endfunction

endpackage

>>> hdl/mesb_cost_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesb_cost_mem
// Cost store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mesb_cost_mem #(
   parameter int ADDR_W = 12,
   parameter int DEPTH  = 4096
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [mesb_pkg::COST_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [mesb_pkg::COST_W-1:0] rd_data
);
   import mesb_pkg::*;

   logic [COST_W-1:0] mem_ff [DEPTH];
   logic [COST_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/mesb_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesb_seq
// Run sequencer: scans the last line for its minimum, then walks back one
// line per result, reading up to three neighbors from the store per step.
// ----------------------------------------------------------------------------
module mesb_seq #(
   parameter int MAX_DIM = 64,
   parameter int ADDR_W  = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         run,
   input  mesb_pkg::run_cfg_type        cfg,
   output logic                         busy,
   output logic                         rd_en,
   output logic [ADDR_W-1:0]            rd_addr,
   input  logic [mesb_pkg::COST_W-1:0]  rd_data,
   output logic                         rsp_strobe,
   output logic [mesb_pkg::POS_W-1:0]   rsp_position,
   output logic [mesb_pkg::IDX_W-1:0]   rsp_path_step,
   output logic                         rsp_last
);
   import mesb_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   run_cfg_type       cfg_ff, cfg_in;
   logic              scan_ff, scan_in;
   logic [IDX_W-1:0]  m_ff, m_in;
   logic [IDX_W-1:0]  x_ff, x_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rd_first_ff, rd_first_in;
   logic [IDX_W-1:0]  rd_x_ff, rd_x_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]  best_x_ff, best_x_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [POS_W-1:0]  rsp_position_ff, rsp_position_in;
   logic [IDX_W-1:0]  rsp_path_step_ff, rsp_path_step_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]  cand_x;
   logic              cand_ok;
   logic              cand_end;
   logic [IDX_W-1:0]  line;
   logic [IDX_W-1:0]  rd_r;
   logic [IDX_W-1:0]  rd_c;
   logic [IDX_W-1:0]  px_r;
   logic [IDX_W-1:0]  px_c;
   logic [POS_W:0]    pos_full;

   // candidate selection for the current issue slot
   always_comb begin
      cand_x   = cnt_ff;
      cand_ok  = 1'b1;
      cand_end = ({1'b0, cnt_ff} == cfg_ff.span - DIM_W'(1));
      if (!scan_ff) begin
         cand_end = (cnt_ff == IDX_W'(2));
         unique case (cnt_ff[1:0])
            2'd0: begin
               cand_x  = x_ff;
               cand_ok = 1'b1;
            end
            2'd1: begin
               cand_x  = x_ff - IDX_W'(1);
               cand_ok = (x_ff != '0);
            end
            default: begin
               cand_x  = x_ff + IDX_W'(1);
               cand_ok = (({1'b0, x_ff} + DIM_W'(1)) < cfg_ff.span);
            end
         endcase
      end
   end

   assign line    = scan_ff ? m_ff : (m_ff - IDX_W'(1));
   assign rd_r    = cfg_ff.horiz ? cand_x : line;
   assign rd_c    = cfg_ff.horiz ? line : cand_x;
   assign rd_en   = (state_ff == ST_ISSUE) && cand_ok;
   assign rd_addr = ADDR_W'(cell_addr(rd_r, rd_c, 32'(MAX_DIM)));

   // running minimum over returned reads: first sets, later ones need strict less
   always_comb begin
      best_in   = best_ff;
      best_x_in = best_x_ff;
      if (rd_valid_ff && (rd_first_ff || (rd_data < best_ff))) begin
         best_in   = rd_data;
         best_x_in = rd_x_ff;
      end
   end

   assign px_r     = cfg_ff.horiz ? x_ff : m_ff;
   assign px_c     = cfg_ff.horiz ? m_ff : x_ff;
   assign pos_full = (POS_W + 1)'(px_r) * (POS_W + 1)'(cfg_ff.cols) + (POS_W + 1)'(px_c);

   always_comb begin
      state_in         = state_ff;
      cfg_in           = cfg_ff;
      scan_in          = scan_ff;
      m_in             = m_ff;
      x_in             = x_ff;
      cnt_in           = cnt_ff;
      rd_valid_in      = 1'b0;
      rd_first_in      = 1'b0;
      rd_x_in          = cand_x;
      rsp_strobe_in    = 1'b0;
      rsp_position_in  = pos_full[POS_W-1:0];
      rsp_path_step_in = m_ff;
      rsp_last_in      = (m_ff == '0);
      unique case (state_ff)
         ST_IDLE: begin
            if (run) begin
               cfg_in   = cfg;
               m_in     = IDX_W'(cfg.len - DIM_W'(1));
               cnt_in   = '0;
               scan_in  = 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            rd_valid_in = cand_ok;
            rd_first_in = (cnt_ff == '0);
            cnt_in      = cnt_ff + IDX_W'(1);
            if (cand_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            x_in     = best_x_in;
            m_in     = line;
            state_in = ST_EMIT;
         end
         default: begin
            rsp_strobe_in = 1'b1;
            cnt_in        = '0;
            scan_in       = 1'b0;
            state_in      = (m_ff == '0) ? ST_IDLE : ST_ISSUE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         scan_ff       <= 1'b0;
         m_ff          <= '0;
         x_ff          <= '0;
         cnt_ff        <= '0;
         best_ff       <= '0;
         best_x_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         scan_ff       <= scan_in;
         m_ff          <= m_in;
         x_ff          <= x_in;
         cnt_ff        <= cnt_in;
         best_ff       <= best_in;
         best_x_ff     <= best_x_in;
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff           <= cfg_in;
      rd_first_ff      <= rd_first_in;
      rd_x_ff          <= rd_x_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_path_step_ff <= rsp_path_step_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_path_step = rsp_path_step_ff;
   assign rsp_last      = rsp_last_ff;

   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff) == ST_EMIT)
      else $error("result strobe without emit");

   a_read_from_issue: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff) == ST_ISSUE)
      else $error("read data tagged outside issue");

   a_walk_above_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE && !scan_ff) |-> m_ff != '0)
      else $error("walk reads beyond first line");

   a_cross_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ({1'b0, x_ff} < cfg_ff.span))
      else $error("seam pixel outside cross extent");

endmodule

>>> hdl/min_energy_seam_backtrack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_energy_seam_backtrack
// Cost store loader, size registers and seam backtrack run control.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions are taken when start is high and busy is low.
//   req_kind load writes req_cost at (req_row_index, req_col_index); loads go
//   at one per cycle while busy is low and produce no result.
//   req_kind run raises busy and walks the stored cost matrix.
//   The csr_ port sets rows, columns and direction; write it while idle.
//   Results come on rsp_position/rsp_path_step/rsp_last, each valid for the
//   single cycle rsp_strobe is high; the receiver cannot stall them.
// Run sequence:
//   First result strobes after a scan of the last line at one store read
//   per cycle (span = cross extent), one compare and one emit. Each further
//   pixel takes three neighbor reads through the single read port, one
//   compare, one emit. busy drops the cycle the final result strobes.
// Reset:
//   Synchronous; rows and columns return to 64, direction to vertical, the
//   sequencer to idle. The cost store is not cleared.
// ----------------------------------------------------------------------------
module min_energy_seam_backtrack #(
   parameter int MAX_DIM = mesb_pkg::MAX_DIM_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_kind,
   input  logic [mesb_pkg::IDX_W-1:0]     req_row_index,
   input  logic [mesb_pkg::IDX_W-1:0]     req_col_index,
   input  logic [mesb_pkg::COST_W-1:0]    req_cost,
   output logic                           rsp_strobe,
   output logic [mesb_pkg::POS_W-1:0]     rsp_position,
   output logic [mesb_pkg::IDX_W-1:0]     rsp_path_step,
   output logic                           rsp_last,
   input  logic                           csr_write_en,
   input  logic [mesb_pkg::CSR_I_W-1:0]   csr_index,
   input  logic [mesb_pkg::DIM_W-1:0]     csr_wdata
);
   import mesb_pkg::*;

   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int DIM_CAP = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;

   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] cols_ff, cols_in;
   logic             dir_ff, dir_in;

   run_cfg_type       run_cfg;
   logic [DIM_W-1:0]  rows_c;
   logic [DIM_W-1:0]  cols_c;
   logic              take;
   logic              run;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [COST_W-1:0] rd_data;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      dir_in  = dir_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
            CSR_DIR:  dir_in  = csr_wdata[0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_W'(64);
         cols_ff <= DIM_W'(64);
         dir_ff  <= 1'b0;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         dir_ff  <= dir_in;
      end
   end

   assign rows_c = clamp_dim(rows_ff, DIM_W'(DIM_CAP));
   assign cols_c = clamp_dim(cols_ff, DIM_W'(DIM_CAP));

   assign run_cfg.horiz = dir_ff;
   assign run_cfg.len   = dir_ff ? cols_c : rows_c;
   assign run_cfg.span  = dir_ff ? rows_c : cols_c;
   assign run_cfg.cols  = cols_c;

   assign take    = start && !busy;
   assign run     = take && (req_kind == KIND_RUN);
   assign wr_en   = take && (req_kind == KIND_LOAD)
                    && (32'(req_row_index) < 32'(MAX_DIM))
                    && (32'(req_col_index) < 32'(MAX_DIM));
   assign wr_addr = ADDR_W'(cell_addr(req_row_index, req_col_index, 32'(MAX_DIM)));

   mesb_cost_mem #(
      .ADDR_W (ADDR_W),
      .DEPTH  (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_cost),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mesb_seq #(
      .MAX_DIM (MAX_DIM),
      .ADDR_W  (ADDR_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .run           (run),
      .cfg           (run_cfg),
      .busy          (busy),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_position  (rsp_position),
      .rsp_path_step (rsp_path_step),
      .rsp_last      (rsp_last)
   );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the minimum energy seam backtrack block.
// Loads cost matrices of many sizes and both directions, starts backtrack
// runs, and checks every emitted seam pixel against a local seam tracer
// that mirrors the cost store and the size and direction registers.
// ----------------------------------------------------------------------------
module tb_top;
   import mesb_pkg::*;

   localparam logic [CSR_I_W-1:0] CSR_SPARE = 2'd3;
   localparam int                 STORE_DIM = MAX_DIM_DEFAULT;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [IDX_W-1:0] step;
      logic             is_last;
   } seam_pixel_type;

   typedef struct packed {
      bit                is_csr;
      bit [CSR_I_W-1:0]  idx;
      bit [DIM_W-1:0]    wdata;
      bit                kind;
      bit [IDX_W-1:0]    row;
      bit [IDX_W-1:0]    col;
      bit [COST_W-1:0]   cost;
      bit                typed;
      bit [POS_W-1:0]    pos;
   } stim_row_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                start         = 1'b0;
   logic                busy;
   logic                req_kind      = KIND_LOAD;
   logic [IDX_W-1:0]    req_row_index = '0;
   logic [IDX_W-1:0]    req_col_index = '0;
   logic [COST_W-1:0]   req_cost      = '0;
   logic                rsp_strobe;
   logic [POS_W-1:0]    rsp_position;
   logic [IDX_W-1:0]    rsp_path_step;
   logic                rsp_last;
   logic                csr_write_en  = 1'b0;
   logic [CSR_I_W-1:0]  csr_index     = '0;
   logic [DIM_W-1:0]    csr_wdata     = '0;

   // mirror of the block state
   bit [COST_W-1:0]     cost_mirror [0:STORE_DIM*STORE_DIM-1];
   bit                  cell_loaded [0:STORE_DIM*STORE_DIM-1];
   logic [DIM_W-1:0]    rows_q = 7'd64;
   logic [DIM_W-1:0]    cols_q = 7'd64;
   logic                dir_q  = 1'b0;

   seam_pixel_type      expected_seam [$];
   seam_pixel_type      want_px;
   stim_row_type        dir_tab [$];
   bit                  no_gap = 1'b0;
   int                  errors = 0;

   always #4 clock = ~clock;

   min_energy_seam_backtrack uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_cost      (req_cost),
      .rsp_strobe    (rsp_strobe),
      .rsp_position  (rsp_position),
      .rsp_path_step (rsp_path_step),
      .rsp_last      (rsp_last),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   function automatic int fit_dim(logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > DIM_LIMIT) return DIM_LIMIT;
      return int'(v);
   endfunction

   function automatic bit [COST_W-1:0] cell_cost(int m, int x, bit horiz);
      return cost_mirror[(horiz ? x : m) * STORE_DIM + (horiz ? m : x)];
   endfunction

   // walk from the cheapest far-end entry back to index 0
   task automatic trace_seam();
      int              nrows, ncols, len, span, m, x, nx, k;
      bit              horiz;
      bit [COST_W-1:0] best, v;
      seam_pixel_type  px;
      horiz = dir_q;
      nrows = fit_dim(rows_q);
      ncols = fit_dim(cols_q);
      len   = horiz ? ncols : nrows;
      span  = horiz ? nrows : ncols;
      m     = len - 1;
      x     = 0;
      best  = cell_cost(m, 0, horiz);
      for (k = 1; k < span; k++) begin
         v = cell_cost(m, k, horiz);
         if (v < best) begin
            best = v;
            x    = k;
         end
      end
      while (1) begin
         px.pos     = POS_W'((horiz ? x : m) * ncols + (horiz ? m : x));
         px.step    = IDX_W'(m);
         px.is_last = (m == 0);
         expected_seam.push_back(px);
         if (m == 0) break;
         nx   = x;
         best = cell_cost(m - 1, x, horiz);
         if (x > 0) begin
            v = cell_cost(m - 1, x - 1, horiz);
            if (v < best) begin
               best = v;
               nx   = x - 1;
            end
         end
         if (x + 1 < span) begin
            v = cell_cost(m - 1, x + 1, horiz);
            if (v < best) begin
               best = v;
               nx   = x + 1;
            end
         end
         x = nx;
         m--;
      end
   endtask

   function automatic logic [COST_W-1:0] rand_cost();
      case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2, 3: begin
            return COST_W'($urandom_range(0, 3));
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return DIM_W'($urandom_range(65, 127));
         end
         2: begin
            return DIM_W'($urandom_range(9, 64));
         end
         default: begin
            return DIM_W'($urandom_range(1, 8));
         end
      endcase
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_I_W-1:0] idx, logic [DIM_W-1:0] v);
      stim_row_type s;
      s        = '0;
      s.is_csr = 1'b1;
      s.idx    = idx;
      s.wdata  = v;
      return s;
   endfunction

   function automatic stim_row_type ld_row(int r, int c, logic [COST_W-1:0] cost);
      stim_row_type s;
      s      = '0;
      s.kind = KIND_LOAD;
      s.row  = IDX_W'(r);
      s.col  = IDX_W'(c);
      s.cost = cost;
      return s;
   endfunction

   // unused fields of a run held at their extremes
   function automatic stim_row_type run_row(bit typed, int pos);
      stim_row_type s;
      s       = '0;
      s.kind  = KIND_RUN;
      s.row   = '1;
      s.col   = '1;
      s.cost  = '1;
      s.typed = typed;
      s.pos   = POS_W'(pos);
      return s;
   endfunction

   // one transaction; start stays high on return unless the caller drops it
   task automatic send_item(logic kind, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                            logic [COST_W-1:0] cost, bit typed = 1'b0,
                            logic [POS_W-1:0] typed_pos = '0);
      int             gap;
      seam_pixel_type px;
      gap = no_gap ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_kind      <= kind;
      req_row_index <= r;
      req_col_index <= c;
      req_cost      <= cost;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind == KIND_LOAD) begin
         cost_mirror[r * STORE_DIM + c] = cost;
         cell_loaded[r * STORE_DIM + c] = 1'b1;
      end else if (typed) begin
         px.pos     = typed_pos;
         px.step    = '0;
         px.is_last = 1'b1;
         expected_seam.push_back(px);
      end else begin
         trace_seam();
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_seam.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_I_W-1:0] idx, logic [DIM_W-1:0] v);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= v;
      @(posedge clock);
      case (idx)
         CSR_ROWS: begin
            rows_q = v;
         end
         CSR_COLS: begin
            cols_q = v;
         end
         CSR_DIR: begin
            dir_q = v[0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic apply_dims(logic [DIM_W-1:0] rv, logic [DIM_W-1:0] cv,
                             logic [DIM_W-1:0] dv);
      wait_idle();
      if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE, DIM_W'($urandom_range(0, 127)));
      write_csr(CSR_ROWS, rv);
      write_csr(CSR_COLS, cv);
      write_csr(CSR_DIR, dv);
      csr_write_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_seam.size() == 0) begin
            $display("%0t: unexpected pixel position %0d step %0d last %0b",
                     $time, rsp_position, rsp_path_step, rsp_last);
            errors++;
         end else begin
            want_px = expected_seam.pop_front();
            if (rsp_position !== want_px.pos) begin
               $display("%0t: position expected %0d got %0d",
                        $time, want_px.pos, rsp_position);
               errors++;
            end
            if (rsp_path_step !== want_px.step) begin
               $display("%0t: path_step expected %0d got %0d",
                        $time, want_px.step, rsp_path_step);
               errors++;
            end
            if (rsp_last !== want_px.is_last) begin
               $display("%0t: last expected %0b got %0b",
                        $time, want_px.is_last, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      bit               in_csr;
      int               phase, rand_items, er, ec, nruns;
      logic [DIM_W-1:0] rv, cv, dv;
      in_csr = 1'b0;
      dir_tab = '{
         csr_row(CSR_ROWS, 7'd1), csr_row(CSR_COLS, 7'd4), csr_row(CSR_DIR, 7'd0),
         ld_row(0, 0, 32'hFFFF_FFFF), ld_row(0, 1, 32'd5), ld_row(0, 2, 32'd5),
         ld_row(0, 3, 32'hFFFF_FFFF),
         run_row(1'b1, 1),                     // tie on the last line: first wins
         ld_row(0, 3, 32'd0),
         run_row(1'b1, 3),
         csr_row(CSR_SPARE, 7'h7F),
         csr_row(CSR_ROWS, 7'd0), csr_row(CSR_COLS, 7'd0),
         run_row(1'b1, 0),                     // zero sizes clamp to 1x1
         ld_row(63, 63, 32'hFFFF_FFFF), ld_row(63, 0, 32'd0), ld_row(0, 63, 32'd1),
         csr_row(CSR_ROWS, 7'd3), csr_row(CSR_COLS, 7'd3),
         ld_row(1, 0, 32'd7), ld_row(1, 1, 32'd7), ld_row(1, 2, 32'd6),
         ld_row(2, 0, 32'd2), ld_row(2, 1, 32'd2), ld_row(2, 2, 32'd9),
         run_row(1'b0, 0),
         csr_row(CSR_DIR, 7'd1),
         run_row(1'b0, 0),
         csr_row(CSR_ROWS, 7'd1), csr_row(CSR_COLS, 7'd4),
         run_row(1'b0, 0),
         csr_row(CSR_ROWS, 7'd3), csr_row(CSR_COLS, 7'd1),
         run_row(1'b1, 2)                      // single column, horizontal
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_csr) begin
            if (!in_csr) wait_idle();
            in_csr = 1'b1;
            write_csr(dir_tab[i].idx, dir_tab[i].wdata);
         end else begin
            if (in_csr) csr_write_en <= 1'b0;
            in_csr = 1'b0;
            send_item(dir_tab[i].kind, dir_tab[i].row, dir_tab[i].col, dir_tab[i].cost,
                      dir_tab[i].typed, dir_tab[i].pos);
         end
      end
      if (in_csr) csr_write_en <= 1'b0;

      phase      = 0;
      rand_items = 0;
      while (rand_items < 150) begin
         case (phase)
            0: begin
               rv = 7'd127; cv = 7'd1;   dv = 7'd0;
            end
            1: begin
               rv = 7'd64;  cv = 7'd0;   dv = 7'h7F;
            end
            2: begin
               rv = 7'd0;   cv = 7'd0;   dv = 7'h7E;
            end
            default: begin
               rv = pick_dim();
               cv = pick_dim();
               dv = DIM_W'($urandom_range(0, 127));
               // keep the matrix to 64 cells or fewer; larger picks fall back to one column
               if (fit_dim(rv) * fit_dim(cv) > 64) cv = 7'd1;
            end
         endcase
         apply_dims(rv, cv, dv);
         no_gap = ($urandom_range(0, 3) == 0);
         er     = fit_dim(rows_q);
         ec     = fit_dim(cols_q);

         // every cell a run may read gets written first
         for (int r = 0; r < er; r++) begin
            for (int c = 0; c < ec; c++) begin
               if (!cell_loaded[r * STORE_DIM + c]) begin
                  send_item(KIND_LOAD, IDX_W'(r), IDX_W'(c), rand_cost());
                  rand_items++;
               end
            end
         end

         nruns = $urandom_range(1, 3);
         repeat (nruns) begin
            repeat ($urandom_range(0, 4)) begin
               send_item(KIND_LOAD, IDX_W'($urandom_range(0, er - 1)),
                         IDX_W'($urandom_range(0, ec - 1)), rand_cost());
               rand_items++;
            end
            if ($urandom_range(0, 2) == 0) begin
               send_item(KIND_LOAD, IDX_W'($urandom), IDX_W'($urandom), rand_cost());
               rand_items++;
            end
            send_item(KIND_RUN, IDX_W'($urandom), IDX_W'($urandom), $urandom);
            rand_items++;
         end
         phase++;
      end

      start <= 1'b0;
      while (expected_seam.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_seam.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
